FILE: hw/rtl/nearest_palette_color_search_defines.svh
// Assertion macros used by the checker file of the palette search block.
// No dependencies; included by bare file name.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define NPCS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("palette search assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define NPCS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("palette search assertion failed");

`endif

FILE: hw/rtl/npcs_pkg.sv
// Shared constants and controller/datapath handshake types for the palette search.
// No dependencies.
package npcs_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
   localparam int DIST_W          = 18;

   // controller -> datapath
   typedef struct packed {
      logic write;       // store the accepted write item
      logic load_query;  // latch query color, restart scan
      logic issue;       // read the next entry
      logic publish;     // move best match into the result register
   } npcs_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last_addr;   // entry being issued is the final one
      logic busy;        // reads still in the compare pipeline
   } npcs_sts_type;

endpackage

FILE: hw/rtl/npcs_req_if.sv
// Request channel: palette writes and color queries.
// No dependencies.
interface npcs_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] entry_index;
   logic [5:0] dac_red;
   logic [5:0] dac_green;
   logic [5:0] dac_blue;
   logic [7:0] query_red;
   logic [7:0] query_green;
   logic [7:0] query_blue;

   modport source (output valid, mode, entry_index, dac_red, dac_green, dac_blue,
                   query_red, query_green, query_blue, input ready);
   modport sink   (input valid, mode, entry_index, dac_red, dac_green, dac_blue,
                   query_red, query_green, query_blue, output ready);
endinterface

FILE: hw/rtl/npcs_rsp_if.sv
// Response channel: nearest entry index and its squared distance.
// No dependencies.
interface npcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  best_index;
   logic [17:0] best_distance;

   modport source (output valid, best_index, best_distance, input ready);
   modport sink   (input valid, best_index, best_distance, output ready);
endinterface

FILE: hw/rtl/nearest_palette_color_search.sv
// Nearest palette color search, 256 entries of 24-bit RGB.
// Write item: stored at the edge on which it is accepted; next item may follow at once.
// Query item: 256 reads, one per cycle, then a 3-stage read/square/compare drain; result
//   published once the previous result has been taken, next item taken after that publish.
// Result sits in an output register; a new item is taken while it waits.
// Synchronous reset: palette reads as black (per-entry valid bits cleared), channels idle.
module nearest_palette_color_search (
   input logic        clock,
   input logic        reset,
   npcs_req_if.sink   req_chan,
   npcs_rsp_if.source rsp_chan
);

   npcs_pkg::npcs_cmd_type cmd;
   npcs_pkg::npcs_sts_type sts;

   // Controller: owns the handshakes and sequences write, scan and result hand-off.
   npcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: palette memory, scan address, distance pipeline and result register.
   npcs_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_entry_index   (req_chan.entry_index),
      .req_dac_red       (req_chan.dac_red),
      .req_dac_green     (req_chan.dac_green),
      .req_dac_blue      (req_chan.dac_blue),
      .req_query_red     (req_chan.query_red),
      .req_query_green   (req_chan.query_green),
      .req_query_blue    (req_chan.query_blue),
      .rsp_best_index    (rsp_chan.best_index),
      .rsp_best_distance (rsp_chan.best_distance)
   );

endmodule

FILE: hw/rtl/npcs_ctrl.sv
// Sequencer for the palette search: accepts items, walks the scan, hands off results.
// Depends on npcs_pkg.
module npcs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_mode,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  npcs_pkg::npcs_sts_type sts,
   output npcs_pkg::npcs_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd            = '0;
      cmd.write      = accept && !req_mode;
      cmd.load_query = accept && req_mode;
      cmd.issue      = (state_ff == ST_SCAN);
      cmd.publish    = (state_ff == ST_DRAIN) && !sts.busy && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load_query) state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (sts.last_addr) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               if (cmd.publish) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: hw/rtl/npcs_dp.sv
// Palette store and distance pipeline: read, square differences, sum and keep minimum.
// Depends on npcs_pkg.
module npcs_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  npcs_pkg::npcs_cmd_type cmd,
   output npcs_pkg::npcs_sts_type sts,
   input  logic [7:0]             req_entry_index,
   input  logic [5:0]             req_dac_red,
   input  logic [5:0]             req_dac_green,
   input  logic [5:0]             req_dac_blue,
   input  logic [7:0]             req_query_red,
   input  logic [7:0]             req_query_green,
   input  logic [7:0]             req_query_blue,
   output logic [7:0]             rsp_best_index,
   output logic [npcs_pkg::DIST_W-1:0] rsp_best_distance
);

   localparam int AW = npcs_pkg::ADDR_W;
   localparam int DW = npcs_pkg::DIST_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(npcs_pkg::PALETTE_ENTRIES - 1);

   function automatic logic [7:0] widen(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return 16'(d) * 16'(d);
   endfunction

   logic [23:0]                          mem [npcs_pkg::PALETTE_ENTRIES];
   logic [npcs_pkg::PALETTE_ENTRIES-1:0] valid_ff;
   logic [AW-1:0]                        waddr;
   logic                                 wr_hit;

   logic [7:0]    q_red_ff, q_green_ff, q_blue_ff;
   logic [AW-1:0] addr_ff;

   // stage 1: registered read
   logic          v1_ff;
   logic [23:0]   rd_data_ff;
   logic          rd_ok_ff;
   logic [AW-1:0] idx1_ff;
   logic [23:0]   color;

   // stage 2: squared component differences
   logic          v2_ff;
   logic [15:0]   sq_r_ff, sq_g_ff, sq_b_ff;
   logic [AW-1:0] idx2_ff;

   // stage 3: running minimum
   logic          first_ff;
   logic [DW-1:0] best_dist_ff;
   logic [AW-1:0] best_idx_ff;
   logic [DW-1:0] sum;

   logic [7:0]    out_index_ff;
   logic [DW-1:0] out_dist_ff;

   assign waddr  = AW'(req_entry_index);
   assign wr_hit = cmd.write && (32'(req_entry_index) < 32'(npcs_pkg::PALETTE_ENTRIES));

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem[waddr] <= {widen(req_dac_red), widen(req_dac_green), widen(req_dac_blue)};
      end
      if (cmd.issue) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   // unwritten entries read as black
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_hit) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         first_ff <= 1'b0;
         addr_ff  <= '0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         if (cmd.load_query) begin
            addr_ff  <= '0;
            first_ff <= 1'b1;
         end else begin
            if (cmd.issue) addr_ff <= addr_ff + AW'(1);
            if (v2_ff) first_ff <= 1'b0;
         end
      end
   end

   assign color = rd_ok_ff ? rd_data_ff : 24'd0;
   assign sum   = DW'(sq_r_ff) + DW'(sq_g_ff) + DW'(sq_b_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         q_red_ff   <= req_query_red;
         q_green_ff <= req_query_green;
         q_blue_ff  <= req_query_blue;
      end
      if (cmd.issue) begin
         rd_ok_ff <= valid_ff[addr_ff];
         idx1_ff  <= addr_ff;
      end
      if (v1_ff) begin
         sq_r_ff <= sq_diff(color[23:16], q_red_ff);
         sq_g_ff <= sq_diff(color[15:8],  q_green_ff);
         sq_b_ff <= sq_diff(color[7:0],   q_blue_ff);
         idx2_ff <= idx1_ff;
      end
      // strict compare keeps the lowest index on ties
      if (v2_ff && (first_ff || (sum < best_dist_ff))) begin
         best_dist_ff <= sum;
         best_idx_ff  <= idx2_ff;
      end
      if (cmd.publish) begin
         out_index_ff <= 8'(best_idx_ff);
         out_dist_ff  <= best_dist_ff;
      end
   end

   always_comb begin
      sts           = '0;
      sts.last_addr = (addr_ff == LAST_ADDR);
      sts.busy      = v1_ff || v2_ff;
   end

   assign rsp_best_index    = out_index_ff;
   assign rsp_best_distance = out_dist_ff;

endmodule

FILE: hw/rtl/npcs_checker.sv
// Port-level checks for the palette search, bound to the top level.
// Depends on nearest_palette_color_search_defines.svh.
`include "nearest_palette_color_search_defines.svh"

module npcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [17:0] rsp_best_distance
);

   logic query_acc;
   logic write_acc;

   assign query_acc = req_valid && req_ready && req_mode;
   assign write_acc = req_valid && req_ready && !req_mode;

   // a stalled result stays offered
   `NPCS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // three squared 8-bit differences never exceed 3*255*255
   `NPCS_ASSERT_IMP(a_dist_max, clock, reset, rsp_valid, rsp_best_distance <= 18'd195075)
   // a query occupies the block for its scan
   `NPCS_ASSERT_NXT(a_query_busy, clock, reset, query_acc, !req_ready)
   // a write leaves the block ready for the next item
   `NPCS_ASSERT_NXT(a_write_fast, clock, reset, write_acc, req_ready)

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_mode          (req_chan.mode),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_best_distance (rsp_chan.best_distance)
);
